[hw/rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// assertion macros
// shared wrappers for clocked concurrent checks with asynchronous reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define LPR_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen outside reset
`define LPR_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	`LPR_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

[hw/rtl/lpr_pkg.sv]
// ---------------------------------------------------------------------------
// lpr_pkg
// types and constants shared by the port remap table modules
// ---------------------------------------------------------------------------
package lpr_pkg;

	localparam int PORT_W  = 16;
	localparam int PROTO_W = 8;
	localparam int CNT_W   = 7;
	localparam int IDX_W   = 6;
	localparam int CHG_W   = 2;

	// entries compared by one lane group
	localparam int GROUP_SIZE = 8;

	localparam logic [PROTO_W-1:0] PROTO_TCP = 8'd6;
	localparam logic [PROTO_W-1:0] PROTO_UDP = 8'd17;

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_REMAP = 1'b1;

	typedef logic [PORT_W-1:0] port_t;

	// best match found by one lane group
	typedef struct packed {
		logic  hit;
		port_t target;
	} lpr_hit_t;

endpackage

[hw/rtl/lpr_lanes.sv]
// ---------------------------------------------------------------------------
// lpr_lanes
// one group of compare lanes, keeps the highest-index hit of the group
// ---------------------------------------------------------------------------
module lpr_lanes
	import lpr_pkg::*;
#(
	parameter int BASE  = 0,
	parameter int TOTAL = 64
) (
	input  port_t                   key,
	input  logic [CNT_W-1:0]        entry_count,
	input  port_t [GROUP_SIZE-1:0]  match_port,
	input  port_t [GROUP_SIZE-1:0]  target_port,
	output lpr_hit_t                found
);

	logic [GROUP_SIZE-1:0] lane_on;

	// a lane is searched if its slot exists and lies below the count
	for (genvar l = 0; l < GROUP_SIZE; l++) begin : g_lane
		localparam logic IN_TABLE = (BASE + l) < TOTAL;
		assign lane_on[l] = IN_TABLE && (32'(entry_count) > 32'(BASE + l));
	end

	// later lanes override earlier ones: highest index wins
	always_comb begin
		found = '0;
		for (int l = 0; l < GROUP_SIZE; l++) begin
			if (lane_on[l] && (match_port[l] == key)) begin
				found.hit    = 1'b1;
				found.target = target_port[l];
			end
		end
	end

endmodule

[hw/rtl/lpr_merge.sv]
// ---------------------------------------------------------------------------
// lpr_merge
// combines lane group results into the new ports and the change count
// ---------------------------------------------------------------------------
module lpr_merge
	import lpr_pkg::*;
#(
	parameter int GROUPS = 8
) (
	input  logic                    remap_en,
	input  port_t                   src_port,
	input  port_t                   dst_port,
	input  lpr_hit_t [GROUPS-1:0]   src_found,
	input  lpr_hit_t [GROUPS-1:0]   dst_found,
	output port_t                   new_src_port,
	output port_t                   new_dst_port,
	output logic [CHG_W-1:0]        change_count
);

	port_t sel_src;
	port_t sel_dst;

	// higher groups hold higher indices
	always_comb begin
		sel_src = src_port;
		sel_dst = dst_port;
		for (int g = 0; g < GROUPS; g++) begin
			if (src_found[g].hit) begin
				sel_src = src_found[g].target;
			end
			if (dst_found[g].hit) begin
				sel_dst = dst_found[g].target;
			end
		end
	end

	// other protocols pass through
	assign new_src_port = remap_en ? sel_src : src_port;
	assign new_dst_port = remap_en ? sel_dst : dst_port;

	assign change_count = CHG_W'(new_src_port != src_port)
		+ CHG_W'(new_dst_port != dst_port);

endmodule

[hw/rtl/l4_port_remap.sv]
// ---------------------------------------------------------------------------
// l4_port_remap
// port remap table for tcp and udp headers with associative lookup
// ---------------------------------------------------------------------------
//
// channel   direction  handshake            payload
// hdr       in         hdr_valid/hdr_stall  action entry_index map_from map_to
//                                           protocol src_port dst_port
// res       out        res_valid/res_stall  new_src_port new_dst_port change_count
// cfg       in         cfg_valid/cfg_ready  cfg_data (entry_count)
//
// one transaction per cycle sustained while res_stall stays low; a remap result passes
// the lane compare into stage 1, then the merge into the output register
// a table write lands at its acceptance edge and gives no result
// reset clears the control state and entry_count; table slots hold nothing
// until written, there is no clearing pass
// res_stall stalls the output register; stage 1 still fills while it waits,
// hdr_stall rises only when stage 1 and the output register both hold results
//
`include "assert_macros.svh"

module l4_port_remap
	import lpr_pkg::*;
#(
	parameter int TABLE_ENTRIES = 64
) (
	input  logic                clk,
	input  logic                arst_n,

	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CNT_W-1:0]    cfg_data,

	input  logic                hdr_valid,
	output logic                hdr_stall,
	input  logic                action,
	input  logic [IDX_W-1:0]    entry_index,
	input  port_t               map_from,
	input  port_t               map_to,
	input  logic [PROTO_W-1:0]  protocol,
	input  port_t               src_port,
	input  port_t               dst_port,

	output logic                res_valid,
	input  logic                res_stall,
	output port_t               new_src_port,
	output port_t               new_dst_port,
	output logic [CHG_W-1:0]    change_count
);

	// table padded up to whole lane groups
	localparam int GROUPS = (TABLE_ENTRIES + GROUP_SIZE - 1) / GROUP_SIZE;
	localparam int PAD    = GROUPS * GROUP_SIZE;

	logic               hdr_accept;
	logic               wr_en;
	logic               remap_en;
	logic               s1_ready;
	logic               out_ready;

	logic [CNT_W-1:0]   entry_count_q;

	port_t [PAD-1:0]    match_all;
	port_t [PAD-1:0]    target_all;

	lpr_hit_t [GROUPS-1:0] src_found;
	lpr_hit_t [GROUPS-1:0] dst_found;

	// stage 1: group results of the lanes
	logic                  valid_s1;
	logic                  remap_en_s1;
	port_t                 src_port_s1;
	port_t                 dst_port_s1;
	lpr_hit_t [GROUPS-1:0] src_found_s1;
	lpr_hit_t [GROUPS-1:0] dst_found_s1;

	// merge outputs
	port_t              mrg_src;
	port_t              mrg_dst;
	logic [CHG_W-1:0]   mrg_chg;

	// output register
	logic               res_valid_q;
	port_t              new_src_q;
	port_t              new_dst_q;
	logic [CHG_W-1:0]   change_count_q;

	// ---- handshakes ----
	assign out_ready  = !res_valid_q || !res_stall;
	assign s1_ready   = !valid_s1 || out_ready;
	assign hdr_stall  = !s1_ready;
	assign hdr_accept = hdr_valid && !hdr_stall;
	assign wr_en      = hdr_accept && (action == ACT_WRITE);
	assign remap_en   = (protocol == PROTO_TCP) || (protocol == PROTO_UDP);

	// ---- configuration: always ready; the user must write it only while idle, not enforced ----
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (cfg_valid) begin
			entry_count_q <= cfg_data;
		end
	end

	// ---- table slots: one pair of registers per entry, no reset ----
	for (genvar i = 0; i < PAD; i++) begin : g_entry
		if (i < TABLE_ENTRIES) begin : g_slot
			logic  wr_hit;
			port_t from_q;
			port_t to_q;

			// slots beyond what entry_index can reach are never written
			if (i < (1 << IDX_W)) begin : g_addr
				assign wr_hit = (entry_index == IDX_W'(i));
			end else begin : g_noaddr
				assign wr_hit = 1'b0;
			end

			always_ff @(posedge clk) begin
				if (wr_en && wr_hit) begin
					from_q <= map_from;
					to_q   <= map_to;
				end
			end

			assign match_all[i]  = from_q;
			assign target_all[i] = to_q;
		end else begin : g_pad
			// padding lanes are never enabled
			assign match_all[i]  = '0;
			assign target_all[i] = '0;
		end
	end

	// ---- lane groups: one bank for each port ----
	for (genvar g = 0; g < GROUPS; g++) begin : g_group
		lpr_lanes #(
			.BASE  (g * GROUP_SIZE),
			.TOTAL (TABLE_ENTRIES)
		) u_src_lanes (
			.key         (src_port),
			.entry_count (entry_count_q),
			.match_port  (match_all[g*GROUP_SIZE +: GROUP_SIZE]),
			.target_port (target_all[g*GROUP_SIZE +: GROUP_SIZE]),
			.found       (src_found[g])
		);

		lpr_lanes #(
			.BASE  (g * GROUP_SIZE),
			.TOTAL (TABLE_ENTRIES)
		) u_dst_lanes (
			.key         (dst_port),
			.entry_count (entry_count_q),
			.match_port  (match_all[g*GROUP_SIZE +: GROUP_SIZE]),
			.target_port (target_all[g*GROUP_SIZE +: GROUP_SIZE]),
			.found       (dst_found[g])
		);
	end

	// ---- stage 1 ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_ready) begin
			// write transactions leave a bubble
			valid_s1 <= hdr_accept && (action == ACT_REMAP);
		end
	end

	always_ff @(posedge clk) begin
		if (s1_ready) begin
			remap_en_s1  <= remap_en;
			src_port_s1  <= src_port;
			dst_port_s1  <= dst_port;
			src_found_s1 <= src_found;
			dst_found_s1 <= dst_found;
		end
	end

	// ---- merge of the group results ----
	lpr_merge #(
		.GROUPS (GROUPS)
	) u_merge (
		.remap_en     (remap_en_s1),
		.src_port     (src_port_s1),
		.dst_port     (dst_port_s1),
		.src_found    (src_found_s1),
		.dst_found    (dst_found_s1),
		.new_src_port (mrg_src),
		.new_dst_port (mrg_dst),
		.change_count (mrg_chg)
	);

	// ---- output register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_ready) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready) begin
			new_src_q      <= mrg_src;
			new_dst_q      <= mrg_dst;
			change_count_q <= mrg_chg;
		end
	end

	assign res_valid    = res_valid_q;
	assign new_src_port = new_src_q;
	assign new_dst_port = new_dst_q;
	assign change_count = change_count_q;

	// ---- checks ----
	// a write transaction never reaches stage 1
	`LPR_ASSERT(a_write_no_result, clk, arst_n,
		(hdr_accept && (action == ACT_WRITE)) |=> !valid_s1, "write produced a result")
	// a waiting stage 1 result is held, not dropped
	`LPR_ASSERT(a_s1_hold, clk, arst_n,
		(valid_s1 && !out_ready) |=> (valid_s1 && $stable(src_port_s1)), "stage 1 result lost")
	// other protocols pass through untouched
	`LPR_ASSERT(a_passthrough, clk, arst_n,
		(valid_s1 && !remap_en_s1) |-> ((mrg_chg == '0) && (mrg_src == src_port_s1)
		&& (mrg_dst == dst_port_s1)), "non tcp/udp header altered")

endmodule
